FILE: hw/rtl/rse_pkg.sv
// Shared constants, types and GF(2^8) arithmetic for the Reed-Solomon encoder.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package rse_pkg;

    localparam int SYM_BITS   = 8;
    localparam int NN         = (1 << SYM_BITS) - 1;
    localparam int MAX_PARITY = 64;
    localparam int NP_BITS    = 7;   // holds 1..MAX_PARITY
    localparam int HEAD_BITS  = 6;   // index into the parity cells
    localparam int POLY_BITS  = SYM_BITS + 1;

    typedef logic [SYM_BITS-1:0] t_sym;

    typedef enum logic [1:0] {
        S_FIELD,   // power sweep, primitivity check, root capture
        S_GEN,     // generator polynomial build, one root per cycle
        S_RUN,     // message words in
        S_EMIT     // parity words out
    } t_state;

    typedef enum logic [1:0] {
        CFG_FIELD_POLY   = 2'd0,
        CFG_FIRST_ROOT   = 2'd1,
        CFG_ROOT_STEP    = 2'd2,
        CFG_PARITY_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic clr;
        logic upd;
    } t_cell_ctl;

    // Shift-and-add multiply, reduced by the field polynomial.
    function automatic t_sym gf_mul(input t_sym a, input t_sym b,
                                    input logic [POLY_BITS-1:0] poly);
        t_sym p;
        p = '0;
        for (int i = SYM_BITS - 1; i >= 0; i--) begin
            p = p[SYM_BITS-1] ? (t_sym'({p, 1'b0}) ^ poly[SYM_BITS-1:0])
                              : t_sym'({p, 1'b0});
            if (b[i]) begin
                p = p ^ a;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rse_gen_cell.sv
// One coefficient cell of the generator polynomial build chain.
// Depends on rse_pkg.
`default_nettype none

module rse_gen_cell (
    input  wire                                i_clk,
    input  wire rse_pkg::t_cell_ctl            i_ctl,
    input  wire rse_pkg::t_sym                 i_init,
    input  wire rse_pkg::t_sym                 i_prev,
    input  wire rse_pkg::t_sym                 i_alpha,
    input  wire [rse_pkg::POLY_BITS-1:0]       i_poly,
    output rse_pkg::t_sym                      o_coef
);

    rse_pkg::t_sym r_coef, n_coef;

    // g'[j] = g[j-1] + g[j] * alpha^root
    always_comb begin
        n_coef = r_coef;
        if (i_ctl.clr) begin
            n_coef = i_init;
        end else if (i_ctl.upd) begin
            n_coef = i_prev ^ rse_pkg::gf_mul(r_coef, i_alpha, i_poly);
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

FILE: hw/rtl/rse_par_cell.sv
// One stage of the parity shift register with its feedback multiplier.
// Depends on rse_pkg.
`default_nettype none

module rse_par_cell (
    input  wire                                i_clk,
    input  wire rse_pkg::t_cell_ctl            i_ctl,
    input  wire rse_pkg::t_sym                 i_next,
    input  wire rse_pkg::t_sym                 i_fb,
    input  wire rse_pkg::t_sym                 i_coef,
    input  wire [rse_pkg::POLY_BITS-1:0]       i_poly,
    output rse_pkg::t_sym                      o_sym
);

    rse_pkg::t_sym r_sym, n_sym;

    always_comb begin
        n_sym = r_sym;
        if (i_ctl.clr) begin
            n_sym = '0;
        end else if (i_ctl.upd) begin
            n_sym = i_next ^ rse_pkg::gf_mul(i_fb, i_coef, i_poly);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    assign o_sym = r_sym;

endmodule

`default_nettype wire

FILE: hw/rtl/reed_solomon_encoder_core.sv
// Reed-Solomon encoder core: control, field sweep and the two cell chains.
// Depends on rse_pkg, rse_gen_cell, rse_par_cell.
// Throughput: one message word per cycle in S_RUN; 255-np words, then np parity words at one
// per cycle while m_tready is high. The first parity word is registered in S_EMIT, which the
// last message word enters. Reset and every config write start a rebuild (field sweep then
// generator build) during which no word is taken; the codeword in progress is dropped.
`default_nettype none

module reed_solomon_encoder_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // config write port
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [8:0]  i_cfg_data,
    // message words in
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,    // [7:0] data_byte
    // parity words out
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,    // [7:0] parity_byte
    output logic       m_tlast,    // last_parity
    output logic [0:0] m_tuser     // [0] config_bad
);

    localparam int MP = rse_pkg::MAX_PARITY;

    // ---------------- configuration registers ----------------
    logic [rse_pkg::POLY_BITS-1:0] r_field_poly;
    rse_pkg::t_sym                 r_first_root, r_root_step;
    logic [rse_pkg::NP_BITS-1:0]   r_parity_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_poly   <= 9'd285;
            r_first_root   <= 8'd1;
            r_root_step    <= 8'd1;
            r_parity_count <= 7'd16;
        end else if (i_cfg_we) begin
            unique case (rse_pkg::t_cfg_idx'(i_cfg_idx))
                rse_pkg::CFG_FIELD_POLY:   r_field_poly   <= i_cfg_data;
                rse_pkg::CFG_FIRST_ROOT:   r_first_root   <= i_cfg_data[7:0];
                rse_pkg::CFG_ROOT_STEP:    r_root_step    <= i_cfg_data[7:0];
                rse_pkg::CFG_PARITY_COUNT: r_parity_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective parity count, clamped to 1..MAX_PARITY
    logic [rse_pkg::NP_BITS-1:0] w_np;
    always_comb begin
        priority if (r_parity_count == '0) begin
            w_np = 7'd1;
        end else if (r_parity_count > 7'(MP)) begin
            w_np = 7'(MP);
        end else begin
            w_np = r_parity_count;
        end
    end

    // roots in log form, mod 255
    rse_pkg::t_sym w_first_m, w_step_m, w_root0;
    logic [15:0]   w_prod;
    logic [8:0]    w_fold1, w_fold2;
    assign w_first_m = (r_first_root == 8'(rse_pkg::NN)) ? '0 : r_first_root;
    assign w_step_m  = (r_root_step  == 8'(rse_pkg::NN)) ? '0 : r_root_step;
    assign w_prod    = 16'(w_first_m) * 16'(w_step_m);
    assign w_fold1   = {1'b0, w_prod[15:8]} + {1'b0, w_prod[7:0]};
    assign w_fold2   = {1'b0, w_fold1[7:0]} + 9'(w_fold1[8]);
    assign w_root0   = (w_fold2 == 9'(rse_pkg::NN)) ? '0 : w_fold2[7:0];

    // ---------------- state ----------------
    rse_pkg::t_state r_state, n_state;
    rse_pkg::t_sym   r_sr, r_i, r_aroot, r_astep, r_cnt;
    logic            r_ok, r_ok_acc;
    logic [rse_pkg::NP_BITS-1:0] r_gi, r_ecnt;
    logic            r_m_valid, r_m_last, r_m_bad;
    rse_pkg::t_sym   r_m_data;

    rse_pkg::t_sym w_sr_next;
    assign w_sr_next = r_sr[7] ? (rse_pkg::t_sym'({r_sr, 1'b0}) ^ r_field_poly[7:0])
                               : rse_pkg::t_sym'({r_sr, 1'b0});

    logic w_in_acc, w_out_load, w_field_end, w_gen_end, w_cw_end, w_emit_end;
    rse_pkg::t_sym w_msg_len;
    assign w_msg_len   = 8'(rse_pkg::NN) - {1'b0, w_np};
    assign w_in_acc    = s_tvalid && s_tready;
    assign w_field_end = (r_i == 8'(rse_pkg::NN - 1));
    assign w_gen_end   = (r_gi == w_np - 7'd1);
    assign w_cw_end    = (8'(r_cnt + 8'd1) == w_msg_len);
    assign w_emit_end  = (r_ecnt == w_np - 7'd1);

    // next state
    always_comb begin
        n_state = r_state;
        priority if (i_cfg_we) begin
            n_state = rse_pkg::S_FIELD;
        end else begin
            unique case (r_state)
                rse_pkg::S_FIELD: if (w_field_end) n_state = rse_pkg::S_GEN;
                rse_pkg::S_GEN:   if (w_gen_end)   n_state = rse_pkg::S_RUN;
                rse_pkg::S_RUN:   if (w_in_acc && w_cw_end) n_state = rse_pkg::S_EMIT;
                rse_pkg::S_EMIT:  if (w_out_load && w_emit_end) n_state = rse_pkg::S_RUN;
                default:          n_state = rse_pkg::S_FIELD;
            endcase
        end
    end

    // state outputs
    rse_pkg::t_cell_ctl w_gen_ctl, w_par_ctl;
    always_comb begin
        s_tready   = 1'b0;
        w_out_load = 1'b0;
        w_gen_ctl  = '0;
        w_par_ctl  = '0;
        unique case (r_state)
            rse_pkg::S_FIELD: begin
                w_gen_ctl.clr = 1'b1;
                w_par_ctl.clr = 1'b1;
            end
            rse_pkg::S_GEN: begin
                w_gen_ctl.upd = 1'b1;
            end
            rse_pkg::S_RUN: begin
                s_tready      = 1'b1;
                w_par_ctl.upd = s_tvalid && r_ok;
            end
            rse_pkg::S_EMIT: begin
                w_out_load    = !r_m_valid || m_tready;
                w_par_ctl.upd = w_out_load;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rse_pkg::S_FIELD;
            r_i       <= '0;
            r_sr      <= 8'd1;
            r_ok_acc  <= 1'b1;
            r_ok      <= 1'b0;
            r_gi      <= '0;
            r_cnt     <= '0;
            r_ecnt    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_i      <= '0;
                r_sr     <= 8'd1;
                r_ok_acc <= 1'b1;
                r_gi     <= '0;
                r_cnt    <= '0;
                r_ecnt   <= '0;
            end else begin
                unique case (r_state)
                    rse_pkg::S_FIELD: begin
                        // a return to 1 before 255 steps means not primitive
                        r_i  <= 8'(r_i + 8'd1);
                        r_sr <= w_sr_next;
                        if (r_i != '0 && r_sr == 8'd1) begin
                            r_ok_acc <= 1'b0;
                        end
                        if (w_field_end) begin
                            r_ok <= r_ok_acc && !(r_sr == 8'd1) && (w_sr_next == 8'd1);
                        end
                    end
                    rse_pkg::S_GEN: begin
                        r_gi <= 7'(r_gi + 7'd1);
                    end
                    rse_pkg::S_RUN: begin
                        if (w_in_acc) begin
                            r_cnt <= w_cw_end ? '0 : 8'(r_cnt + 8'd1);
                        end
                    end
                    rse_pkg::S_EMIT: begin
                        if (w_out_load) begin
                            r_ecnt <= w_emit_end ? '0 : 7'(r_ecnt + 7'd1);
                        end
                    end
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // root captures during the sweep; root advance during the build
    always_ff @(posedge i_clk) begin
        if (r_state == rse_pkg::S_FIELD) begin
            if (r_i == w_root0)  r_aroot <= r_sr;
            if (r_i == w_step_m) r_astep <= r_sr;
        end else if (r_state == rse_pkg::S_GEN) begin
            r_aroot <= rse_pkg::gf_mul(r_aroot, r_astep, r_field_poly);
        end
    end

    // ---------------- cell chains ----------------
    rse_pkg::t_sym w_gen [0:MP];
    rse_pkg::t_sym w_par [0:MP-1];

    for (genvar j = 0; j <= MP; j++) begin : g_gen
        rse_gen_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_gen_ctl),
            .i_init ((j == 0) ? 8'd1 : 8'd0),
            .i_prev ((j == 0) ? 8'd0 : w_gen[(j == 0) ? 0 : j - 1]),
            .i_alpha(r_aroot),
            .i_poly (r_field_poly),
            .o_coef (w_gen[j])
        );
    end

    // the live register sits in the top np cells: cell k holds parity k-(64-np)
    logic [rse_pkg::HEAD_BITS-1:0] w_head_idx;
    rse_pkg::t_sym w_head, w_fb;
    assign w_head_idx = 6'(7'(MP) - w_np);
    assign w_head     = w_par[w_head_idx];
    assign w_fb       = (r_state == rse_pkg::S_RUN) ? (s_tdata ^ w_head) : '0;

    for (genvar k = 0; k < MP; k++) begin : g_par
        rse_pkg::t_cell_ctl w_ctl;
        assign w_ctl = '{clr: w_par_ctl.clr,
                         upd: w_par_ctl.upd && ((8'(k) + {1'b0, w_np}) >= 8'(MP))};
        rse_par_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_next((k == MP - 1) ? 8'd0 : w_par[(k == MP - 1) ? k : k + 1]),
            .i_fb  (w_fb),
            .i_coef(w_gen[MP - 1 - k]),
            .i_poly(r_field_poly),
            .o_sym (w_par[k])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= r_ok ? w_head : '0;
            r_m_last <= w_emit_end;
            r_m_bad  <= !r_ok;
        end
    end

    assign m_tvalid   = r_m_valid;
    assign m_tdata    = r_m_data;
    assign m_tlast    = r_m_last;
    assign m_tuser[0] = r_m_bad;

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("parity word not zero with bad field");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::S_RUN) |-> (r_cnt < w_msg_len))
        else $error("symbol count past message length");
    a_emit_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rse_pkg::S_EMIT && w_out_load && w_emit_end && !i_cfg_we)
            |=> (r_state == rse_pkg::S_RUN && m_tvalid && m_tlast))
        else $error("last parity not followed by return to run");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for reed_solomon_encoder_core: directed codewords, then random ones.
// Depends on rse_pkg and the encoder RTL; holds its own GF(2^8) encoder model as the predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 6000;  // must outlast a rebuild and the long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;
    localparam int NN             = rse_pkg::NN;
    localparam int MAXP           = rse_pkg::MAX_PARITY;

    typedef enum int {PAT_ZERO, PAT_ONES, PAT_RAMP, PAT_RAND} t_pat;

    typedef struct {
        bit   wr;       // write all four registers first
        int   poly;
        int   first;
        int   step;
        int   np;
        t_pat pat;
        int   cut;      // words sent before dropping the codeword, 0 = full codeword
        bit   typed;    // expected parity typed in: all zero, config_bad as given
        bit   typed_bad;
    } t_row;

    typedef struct {
        logic [7:0] parity;
        logic       last;
        logic       bad;
    } t_parity_word;

    logic       i_clk, i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [8:0] i_cfg_data;
    logic       s_tvalid, s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid, m_tready, m_tlast;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;

    reed_solomon_encoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // ---------------- encoder model ----------------
    int  cfg_poly, cfg_first, cfg_step, cfg_np;
    int  alog [0:255];
    int  glog [0:255];
    int  gen_log [0:MAXP];
    int  par_reg [0:MAXP-1];
    int  sym_cnt;
    bit  field_good;
    bit  typed_mode, typed_bad;       // directed rows with expectations read off by hand
    t_parity_word parity_q[$];

    function automatic int eff_np();
        int p;
        p = cfg_np;
        if (p < 1) p = 1;
        if (p > MAXP) p = MAXP;
        return p;
    endfunction

    function automatic void rebuild_code();
        int sr, np, step, root;
        int g [0:MAXP];
        bit ok;
        sr = 1;
        ok = 1'b1;
        np = eff_np();
        for (int i = 0; i < 256; i++) begin
            alog[i] = 0;
            glog[i] = 0;
        end
        // power sweep; a return to 1 before NN steps means not primitive
        for (int i = 0; i < NN; i++) begin
            if (i > 0 && sr == 1) ok = 1'b0;
            glog[sr & NN] = i;
            alog[i] = sr;
            sr = sr << 1;
            if (sr & 256) sr = sr ^ cfg_poly;
            sr = sr & NN;
        end
        if (sr != 1) ok = 1'b0;
        glog[0] = NN;
        alog[NN] = 0;
        field_good = ok;
        for (int i = 0; i <= MAXP; i++) begin
            gen_log[i] = NN;
            g[i] = 0;
        end
        if (ok) begin
            step = cfg_step % NN;
            root = ((cfg_first % NN) * step) % NN;
            g[0] = 1;
            for (int i = 0; i < np; i++) begin
                g[i+1] = 1;
                for (int j = i; j > 0; j--) begin
                    if (g[j] != 0) g[j] = g[j-1] ^ alog[(glog[g[j]] + root) % NN];
                    else g[j] = g[j-1];
                end
                g[0] = alog[(glog[g[0]] + root) % NN];
                root = (root + step) % NN;
            end
            for (int i = 0; i <= np; i++) gen_log[i] = glog[g[i] & NN];
        end
        for (int i = 0; i < MAXP; i++) par_reg[i] = 0;
        sym_cnt = 0;
    endfunction

    // one message word in; queues the parity words when the codeword completes
    function automatic void encode_word(input logic [7:0] d);
        int np, fb, gl;
        t_parity_word w;
        np = eff_np();
        if (field_good) begin
            fb = glog[(d ^ par_reg[0]) & NN];
            if (fb != NN) begin
                for (int j = 1; j < np; j++) begin
                    gl = gen_log[np-j];
                    if (gl != NN) par_reg[j] = par_reg[j] ^ alog[(fb + gl) % NN];
                end
            end
            for (int j = 0; j + 1 < np; j++) par_reg[j] = par_reg[j+1];
            if (fb != NN && gen_log[0] != NN) par_reg[np-1] = alog[(fb + gen_log[0]) % NN];
            else par_reg[np-1] = 0;
        end
        sym_cnt++;
        if (sym_cnt < NN - np) return;
        for (int k = 0; k < np; k++) begin
            if (typed_mode) begin
                w.parity = 8'd0;
                w.bad    = typed_bad;
            end else begin
                w.parity = field_good ? par_reg[k][7:0] : 8'd0;
                w.bad    = !field_good;
            end
            w.last = (k + 1 == np);
            parity_q.push_back(w);
        end
        for (int i = 0; i < MAXP; i++) par_reg[i] = 0;
        sym_cnt = 0;
    endfunction

    // ---------------- stimulus control ----------------
    int  tx_idle, rx_idle;     // percent of cycles each side idles
    int  rx_hold;              // long receiver hold-off, counted down below
    int  mismatches;
    int  quiet_cycles;
    logic accepted_any;

    // receiver: random stalls plus the long hold-off
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // parity word checker; values read at the edge are the pre-edge ones
    always @(posedge i_clk) begin
        t_parity_word w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (parity_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected parity word %02h last=%0b bad=%0b",
                             m_tdata, m_tlast, m_tuser[0]);
            end else begin
                w = parity_q.pop_front();
                if (m_tdata !== w.parity || m_tlast !== w.last || m_tuser[0] !== w.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("parity word: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 w.parity, w.last, w.bad, m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        accepted_any = (s_tvalid && s_tready) || (m_tvalid && m_tready);
        if (!i_rst_n || accepted_any) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offers one message word, with an optional gap first; returns at the accepting edge
    task automatic send_word(input logic [7:0] d);
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        encode_word(d);
    endtask

    task automatic send_codeword(input t_pat pat, input int cut);
        int n;
        logic [7:0] d;
        n = (cut > 0) ? cut : NN - eff_np();
        for (int i = 0; i < n; i++) begin
            case (pat)
                PAT_ZERO: d = 8'h00;
                PAT_ONES: d = 8'hFF;
                PAT_RAMP: d = i[7:0];
                default: begin
                    // mostly random words, some set to the extremes
                    case ($urandom_range(9))
                        0:       d = 8'h00;
                        1:       d = 8'hFF;
                        default: d = $urandom_range(255);
                    endcase
                end
            endcase
            send_word(d);
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // block must be idle: no parity word pending and the pipe given time to drain
    task automatic wait_drained();
        while (parity_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; write_all drops it
    task automatic write_reg(input rse_pkg::t_cfg_idx idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[8:0];
        @(posedge i_clk);
        case (idx)
            rse_pkg::CFG_FIELD_POLY:   cfg_poly  = val & 9'h1FF;
            rse_pkg::CFG_FIRST_ROOT:   cfg_first = val & 8'hFF;
            rse_pkg::CFG_ROOT_STEP:    cfg_step  = val & 8'hFF;
            rse_pkg::CFG_PARITY_COUNT: cfg_np    = val & 7'h7F;
        endcase
        rebuild_code();
    endtask

    task automatic write_all(input int poly, input int first, input int step, input int np);
        wait_drained();
        write_reg(rse_pkg::CFG_FIELD_POLY, poly);
        write_reg(rse_pkg::CFG_FIRST_ROOT, first);
        write_reg(rse_pkg::CFG_ROOT_STEP, step);
        write_reg(rse_pkg::CFG_PARITY_COUNT, np);
        i_cfg_we <= 1'b0;
    endtask

    // directed codewords
    t_row rows [] = '{
        // reset settings, zero message: parity all zero
        '{0, 285, 1, 1, 16, PAT_ZERO, 0, 1, 0},
        '{0, 285, 1, 1, 16, PAT_ONES, 0, 0, 0},
        // codeword dropped part way by the next write
        '{0, 285, 1, 1, 16, PAT_RAND, 50, 0, 0},
        '{1, 285, 0, 1, 64, PAT_RAMP, 0, 0, 0},
        // root values at NN wrap to zero
        '{1, 285, 255, 255, 64, PAT_RAND, 0, 0, 0},
        // zero step: every root is 1, so even powers of (x+1) give zero coefficients
        '{1, 285, 1, 0, 64, PAT_ONES, 0, 0, 0},
        // parity count below range, raised to one
        '{1, 301, 7, 3, 0, PAT_RAND, 0, 0, 0},
        // parity count above range, lowered to the maximum
        '{1, 511, 200, 17, 127, PAT_RAND, 0, 0, 0},
        // x^8 alone is not primitive: zero parity, config_bad set
        '{1, 256, 1, 1, 64, PAT_RAND, 0, 1, 1},
        '{1, 357, 3, 5, 64, PAT_ONES, 0, 0, 0},
        '{1, 285, 1, 1, 64, PAT_ZERO, 0, 1, 0}
    };

    int prim_polys [] = '{285, 301, 333, 351, 355, 357, 361, 369,
                          391, 397, 425, 451, 463, 487, 501};

    initial begin
        int np, poly, first, step;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = rse_pkg::CFG_FIELD_POLY;
        i_cfg_data = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        rx_hold    = 0;
        mismatches = 0;
        quiet_cycles = 0;
        typed_mode = 1'b0;
        typed_bad  = 1'b0;
        tx_idle    = 30;
        rx_idle    = 47;
        cfg_poly = 285; cfg_first = 1; cfg_step = 1; cfg_np = 16;
        rebuild_code();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].wr)
                write_all(rows[r].poly, rows[r].first, rows[r].step, rows[r].np);
            typed_mode = rows[r].typed;
            typed_bad  = rows[r].typed_bad;
            send_codeword(rows[r].pat, rows[r].cut);
            typed_mode = 1'b0;
            // the sender waits for every parity word before the next row
            while (parity_q.size() != 0) @(posedge i_clk);
        end

        // random part, three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 30 : (ph == 1) ? 47 : 0;
            rx_idle = (ph == 0) ? 47 : (ph == 1) ? 30 : 0;
            for (int c = 0; c < 3; c++) begin
                poly = ($urandom_range(9) == 0) ? $urandom_range(256, 511)
                                                : prim_polys[$urandom_range(prim_polys.size()-1)];
                np = ($urandom_range(4) == 0) ? $urandom_range(1, 64) : $urandom_range(48, 64);
                first = $urandom_range(255);
                step  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 255);
                write_all(poly, first, step, np);
                send_codeword(PAT_RAND, 0);
                if (ph == 2 && c == 1) begin
                    // receiver holds off; sender presses straight on so the block backs up
                    rx_hold = 400;
                    send_codeword(PAT_RAND, 0);
                end else if (c == 0) begin
                    send_codeword(PAT_RAND, 0);
                end
            end
        end

        while (parity_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
